FILE: sv/pmt_pkg.sv
// Shared types, constants and arithmetic helpers for the 64-bit primality tester.
package pmt_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned NUM_PRIMES  = 14;
    localparam int unsigned RES_W       = 6;

    // test modes handed from front to back
    typedef enum logic [1:0] {
        MODE_DIRECT = 2'd0,
        MODE_FERMAT = 2'd1,
        MODE_STRONG = 2'd2
    } mode_t;

    typedef struct packed {
        logic [WORD_W-1:0] n;
        mode_t             mode;
        logic [2:0]        set_sel;
        logic              direct;
    } qent_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] m;
    } mm_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] res;
    } mm_rsp_t;

    // 3 and 5 first, then the trial-division primes 7..47
    function automatic logic [RES_W-1:0] prime_at(input logic [3:0] idx);
        logic [RES_W-1:0] p;
        begin
            case (idx)
                4'd0:    p = 6'd3;
                4'd1:    p = 6'd5;
                4'd2:    p = 6'd7;
                4'd3:    p = 6'd11;
                4'd4:    p = 6'd13;
                4'd5:    p = 6'd17;
                4'd6:    p = 6'd19;
                4'd7:    p = 6'd23;
                4'd8:    p = 6'd29;
                4'd9:    p = 6'd31;
                4'd10:   p = 6'd37;
                4'd11:   p = 6'd41;
                4'd12:   p = 6'd43;
                4'd13:   p = 6'd47;
                default: p = 6'd1;
            endcase
            return p;
        end
    endfunction

    // ceil(2^20 / p) for the same primes; exact quotients for dividends below 2^14
    function automatic logic [19:0] recip_at(input logic [3:0] idx);
        logic [19:0] v;
        begin
            case (idx)
                4'd0:    v = 20'd349526;
                4'd1:    v = 20'd209716;
                4'd2:    v = 20'd149797;
                4'd3:    v = 20'd95326;
                4'd4:    v = 20'd80660;
                4'd5:    v = 20'd61681;
                4'd6:    v = 20'd55189;
                4'd7:    v = 20'd45591;
                4'd8:    v = 20'd36158;
                4'd9:    v = 20'd33826;
                4'd10:   v = 20'd28340;
                4'd11:   v = 20'd25576;
                4'd12:   v = 20'd24386;
                4'd13:   v = 20'd22311;
                default: v = 20'd0;
            endcase
            return v;
        end
    endfunction

    // (r * 256 + byte_in) mod p, with r < p
    function automatic logic [RES_W-1:0] fold_byte(input logic [3:0]       idx,
                                                   input logic [RES_W-1:0] r,
                                                   input logic [7:0]       byte_in);
        logic [13:0] t;
        logic [33:0] prod;
        logic [13:0] q;
        logic [13:0] rem;
        begin
            t    = {r, byte_in};
            prod = {20'd0, t} * {14'd0, recip_at(idx)};
            q    = prod[33:20];
            rem  = t - q * {8'd0, prime_at(idx)};
            return rem[RES_W-1:0];
        end
    endfunction

    // (x + y) mod m for x, y < m
    function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] y,
                                                  input logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] room;
        begin
            room = m - y;
            return (x >= room) ? (x - room) : (x + y);
        end
    endfunction

    // witness bases; sel picks the set, idx the base within it
    function automatic logic [WORD_W-1:0] base_of(input logic [2:0] sel,
                                                  input logic [2:0] idx);
        logic [WORD_W-1:0] v;
        begin
            v = 64'd2;
            case ({sel, idx})
                6'o00: v = 64'd9345883071009581737;
                6'o10: v = 64'd725270293939359937;
                6'o11: v = 64'd3569819667048198375;
                6'o20: v = 64'd4230279247111683200;
                6'o21: v = 64'd14694767155120705706;
                6'o22: v = 64'd16641139526367750375;
                6'o30: v = 64'd2;
                6'o31: v = 64'd141889084524735;
                6'o32: v = 64'd1199124725622454117;
                6'o33: v = 64'd11096072698276303650;
                6'o40: v = 64'd2;
                6'o41: v = 64'd4130806001517;
                6'o42: v = 64'd149795463772692060;
                6'o43: v = 64'd186635894390467037;
                6'o44: v = 64'd3967304179347715805;
                6'o50: v = 64'd2;
                6'o51: v = 64'd123635709730000;
                6'o52: v = 64'd9233062284813009;
                6'o53: v = 64'd43835965440333360;
                6'o54: v = 64'd761179012939631437;
                6'o55: v = 64'd1263739024124850375;
                6'o60: v = 64'd2;
                6'o61: v = 64'd325;
                6'o62: v = 64'd9375;
                6'o63: v = 64'd28178;
                6'o64: v = 64'd450775;
                6'o65: v = 64'd9780504;
                6'o66: v = 64'd1795265022;
                default: v = 64'd2;
            endcase
            return v;
        end
    endfunction

    // base-2 pseudoprimes in the Fermat range
    function automatic logic fermat_liar(input logic [WORD_W-1:0] n);
        return (n == 64'd7957) || (n == 64'd8321) || (n == 64'd13747) ||
               (n == 64'd18721) || (n == 64'd19951);
    endfunction

endpackage

FILE: sv/pmt_front.sv
// Front end: accept candidates, screen by trial division, classify the test.
module pmt_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pmt_pkg::WORD_W-1:0] candidate,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      push,
    output pmt_pkg::qent_t            push_ent,
    input  logic                      full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SCAN = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                     state_reg, state_next;
    logic [pmt_pkg::WORD_W-1:0]  n_reg, n_next;
    logic [pmt_pkg::WORD_W-1:0]  sh_reg, sh_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [pmt_pkg::RES_W-1:0]   res_reg  [pmt_pkg::NUM_PRIMES];
    logic [pmt_pkg::RES_W-1:0]   res_next [pmt_pkg::NUM_PRIMES];
    logic                        trial_hit;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate;
                    sh_next    = candidate;
                    cnt_next   = '0;
                    for (int k = 0; k < pmt_pkg::NUM_PRIMES; k++)
                        res_next[k] = '0;
                    state_next = F_SCAN;
                end
            end
            F_SCAN:
            begin
                // one byte per cycle into every residue, MSB first
                for (int k = 0; k < pmt_pkg::NUM_PRIMES; k++)
                    res_next[k] = pmt_pkg::fold_byte(4'(k), res_reg[k],
                        sh_reg[pmt_pkg::WORD_W-1:pmt_pkg::WORD_W-8]);
                sh_next  = {sh_reg[pmt_pkg::WORD_W-9:0], 8'd0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        trial_hit = 1'b0;
        for (int k = 2; k < pmt_pkg::NUM_PRIMES; k++)
            if (res_reg[k] == '0)
                trial_hit = 1'b1;
    end

    // classification of the scanned number
    always_comb
    begin
        push_ent.n       = n_reg;
        push_ent.mode    = pmt_pkg::MODE_DIRECT;
        push_ent.set_sel = 3'd0;
        push_ent.direct  = 1'b0;
        if (n_reg == 64'd2 || n_reg == 64'd3 || n_reg == 64'd5)
            push_ent.direct = 1'b1;
        else if (n_reg < 64'd2 || !n_reg[0] || res_reg[0] == '0 || res_reg[1] == '0)
            push_ent.direct = 1'b0;
        else if (n_reg < 64'd49)
            push_ent.direct = 1'b1;
        else if (trial_hit)
            push_ent.direct = 1'b0;
        else if (n_reg < 64'd2809)
            push_ent.direct = 1'b1;
        else if (n_reg <= 64'd23001)
            push_ent.mode = pmt_pkg::MODE_FERMAT;
        else
        begin
            push_ent.mode = pmt_pkg::MODE_STRONG;
            if (n_reg < 64'd341531)
                push_ent.set_sel = 3'd0;
            else if (n_reg < 64'd885594169)
                push_ent.set_sel = 3'd1;
            else if (n_reg < 64'd350269456337)
                push_ent.set_sel = 3'd2;
            else if (n_reg < 64'd55245642489451)
                push_ent.set_sel = 3'd3;
            else if (n_reg < 64'd7999252175582851)
                push_ent.set_sel = 3'd4;
            else if (n_reg < 64'd585226005592931977)
                push_ent.set_sel = 3'd5;
            else
                push_ent.set_sel = 3'd6;
        end
    end

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

endmodule

FILE: sv/pmt_queue.sv
// Short request queue between front end and back end.
module pmt_queue
#(
    parameter int unsigned DEPTH = pmt_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pmt_pkg::qent_t push_ent,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output pmt_pkg::qent_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pmt_pkg::qent_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? bump(wr_reg) : wr_reg;
        rd_next  = pop  ? bump(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_ent;
    end

endmodule

FILE: sv/pmt_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module pmt_mulmod
(
    input  logic             clk,
    input  logic             rst_n,
    input  pmt_pkg::mm_req_t req,
    output pmt_pkg::mm_rsp_t rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic [pmt_pkg::WORD_W-1:0] r_reg, r_next, a_reg, a_next;
    logic [pmt_pkg::WORD_W-1:0] b_reg, b_next, m_reg, m_next;
    logic [pmt_pkg::WORD_W-1:0] dbl;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        dbl       = pmt_pkg::add_mod(r_reg, r_reg, m_reg);
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            r_next    = '0;
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
        end
        else if (busy_reg)
        begin
            r_next   = b_reg[pmt_pkg::WORD_W-1] ? pmt_pkg::add_mod(dbl, a_reg, m_reg) : dbl;
            b_next   = {b_reg[pmt_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

endmodule

FILE: sv/pmt_back.sv
// Back end: runs the Fermat or strong-probable-prime test on the shared multiplier.
module pmt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  pmt_pkg::qent_t   q_head,
    output logic             q_pop,
    output pmt_pkg::mm_req_t mm_req,
    input  pmt_pkg::mm_rsp_t mm_rsp,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             is_prime
);

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_DS   = 8'b0000_0010,
        B_RED  = 8'b0000_0100,
        B_PACC = 8'b0000_1000,
        B_PSQ  = 8'b0001_0000,
        B_SQR  = 8'b0010_0000,
        B_OUT  = 8'b0100_0000,
        B_WAIT = 8'b1000_0000
    } bstate_t;

    localparam int unsigned W = pmt_pkg::WORD_W;

    bstate_t         state_reg, state_next;
    pmt_pkg::mode_t  mode_reg, mode_next;
    logic [2:0]      set_reg, set_next, bi_reg, bi_next;
    logic [W-1:0]    n_reg, n_next, d_reg, d_next, e_reg, e_next;
    logic [W-1:0]    acc_reg, acc_next, b_reg, b_next, x_reg, x_next;
    logic [W-1:0]    opa_reg, opa_next, opb_reg, opb_next;
    logic [5:0]      s_reg, s_next, j_reg, j_next;
    logic            start_reg, start_next;
    logic            res_reg, res_next;

    logic            pow_go, next_base, fail, red_go, probe;
    logic [W-1:0]    e_go, xv;
    logic [2:0]      red_idx;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        set_next   = set_reg;
        bi_next    = bi_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        s_next     = s_reg;
        j_next     = j_reg;
        start_next = 1'b0;
        res_next   = res_reg;
        q_pop      = 1'b0;
        pow_go     = 1'b0;
        e_go       = e_reg;
        next_base  = 1'b0;
        fail       = 1'b0;
        red_go     = 1'b0;
        red_idx    = bi_reg;
        probe      = 1'b0;
        xv         = x_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    n_next    = q_head.n;
                    mode_next = q_head.mode;
                    set_next  = q_head.set_sel;
                    case (q_head.mode)
                        pmt_pkg::MODE_FERMAT:
                        begin
                            acc_next = 64'd1;
                            b_next   = 64'd2;
                            pow_go   = 1'b1;
                            e_go     = q_head.n;
                        end
                        pmt_pkg::MODE_STRONG:
                        begin
                            d_next     = q_head.n - 64'd1;
                            s_next     = '0;
                            state_next = B_DS;
                        end
                        default:
                        begin
                            res_next   = q_head.direct;
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_DS:
            begin
                // strip trailing zeros of n-1
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    s_next = s_reg + 6'd1;
                end
                else
                begin
                    red_go  = 1'b1;
                    red_idx = 3'd0;
                end
            end
            B_RED:
            begin
                if (mm_rsp.done)
                begin
                    if (mm_rsp.res < 64'd2)
                        next_base = 1'b1;
                    else
                    begin
                        acc_next = 64'd1;
                        b_next   = mm_rsp.res;
                        pow_go   = 1'b1;
                        e_go     = d_reg;
                    end
                end
            end
            B_PACC:
            begin
                if (mm_rsp.done)
                begin
                    acc_next   = mm_rsp.res;
                    start_next = 1'b1;
                    opa_next   = b_reg;
                    opb_next   = b_reg;
                    state_next = B_PSQ;
                end
            end
            B_PSQ:
            begin
                if (mm_rsp.done)
                begin
                    b_next = mm_rsp.res;
                    pow_go = 1'b1;
                    e_go   = {1'b0, e_reg[W-1:1]};
                end
            end
            B_SQR:
            begin
                if (mm_rsp.done)
                begin
                    x_next = mm_rsp.res;
                    if (mm_rsp.res == n_reg - 64'd1)
                        next_base = 1'b1;
                    else if (mm_rsp.res == 64'd1)
                        fail = 1'b1;
                    else if ({1'b0, j_reg} + 7'd1 < {1'b0, s_reg})
                    begin
                        j_next     = j_reg + 6'd1;
                        start_next = 1'b1;
                        opa_next   = mm_rsp.res;
                        opb_next   = mm_rsp.res;
                    end
                    else
                        fail = 1'b1;
                end
            end
            B_OUT:
            begin
                if (out_ready)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase

        // one step of square-and-multiply, LSB of the exponent first
        if (pow_go)
        begin
            e_next = e_go;
            if (e_go == '0)
            begin
                if (mode_next == pmt_pkg::MODE_FERMAT)
                begin
                    res_next   = (acc_next == 64'd2) && !pmt_pkg::fermat_liar(n_next);
                    state_next = B_OUT;
                end
                else
                begin
                    probe = 1'b1;
                    xv    = acc_next;
                end
            end
            else
            begin
                start_next = 1'b1;
                opa_next   = e_go[0] ? acc_next : b_next;
                opb_next   = b_next;
                state_next = e_go[0] ? B_PACC : B_PSQ;
            end
        end

        if (probe)
        begin
            x_next = xv;
            if (xv == 64'd1 || xv == n_reg - 64'd1)
                next_base = 1'b1;
            else if (s_reg > 6'd1)
            begin
                j_next     = 6'd1;
                start_next = 1'b1;
                opa_next   = xv;
                opb_next   = xv;
                state_next = B_SQR;
            end
            else
                fail = 1'b1;
        end

        if (next_base)
        begin
            if (bi_reg == set_reg)
            begin
                res_next   = 1'b1;
                state_next = B_OUT;
            end
            else
            begin
                red_go  = 1'b1;
                red_idx = bi_reg + 3'd1;
            end
        end

        if (fail)
        begin
            res_next   = 1'b0;
            state_next = B_OUT;
        end

        // reduce the base: 1 * base mod n
        if (red_go)
        begin
            bi_next    = red_idx;
            start_next = 1'b1;
            opa_next   = 64'd1;
            opb_next   = pmt_pkg::base_of(set_reg, red_idx);
            state_next = B_RED;
        end
    end

    assign mm_req.start = start_reg;
    assign mm_req.a     = opa_reg;
    assign mm_req.b     = opb_reg;
    assign mm_req.m     = n_reg;
    assign out_valid    = (state_reg == B_OUT);
    assign is_prime     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        set_reg  <= set_next;
        bi_reg   <= bi_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        s_reg    <= s_next;
        j_reg    <= j_next;
        res_reg  <= res_next;
    end

endmodule

FILE: sv/primality_test_64bit_top.sv
// Top level of the deterministic 64-bit primality tester.
//
//  channel | signals                     | dir | meaning
//  --------+-----------------------------+-----+------------------------------
//  in      | in_valid, in_ready, candidate | in  | one 64-bit number per request
//  out     | out_valid, out_ready, is_prime| out | 1 = prime, 0 = composite/<2
//
// Work: the front end handles a request in steps (accept, byte-wise trial division
// of all eight bytes by reciprocal multiplication, one push). The back end
// runs each product on the bit-serial modular multiplier (issue, 64 steps,
// completion): no products for screened values, at most 28 for the Fermat range,
// and up to seven bases of about 130 products each for large n; the shared
// multiplier sets the throughput.
// Reset: rst_n clears all control state at once; no clearing pass is needed.
// Stalls: the front end keeps screening while the back end is busy, until the
// queue fills; a result holds on out_valid until out_ready takes it.
module primality_test_64bit_top
#(
    parameter int unsigned QUEUE_DEPTH = pmt_pkg::QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [pmt_pkg::WORD_W-1:0] candidate,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_prime
);

    logic             push, full, pop, not_empty;
    pmt_pkg::qent_t   push_ent, head;
    pmt_pkg::mm_req_t mm_req;
    pmt_pkg::mm_rsp_t mm_rsp;

    // screen and classify each request
    pmt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .candidate(candidate),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .push     (push),
        .push_ent (push_ent),
        .full     (full)
    );

    // decouple front and back
    pmt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .full     (full),
        .pop      (pop),
        .not_empty(not_empty),
        .head     (head)
    );

    // run the exponentiation tests
    pmt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .q_head   (head),
        .q_pop    (pop),
        .mm_req   (mm_req),
        .mm_rsp   (mm_rsp),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_prime (is_prime)
    );

    // shared modular multiplier
    pmt_mulmod u_mulmod
    (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mm_req),
        .rsp  (mm_rsp)
    );

`ifndef NO_ASSERTIONS
    // never start a product while one is running
    a_mm_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mm_req.start |-> !mm_rsp.busy)
        else $error("multiplier restarted while busy");

    // the queue never takes a push while full
    a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue overflow");

    // done is raised only as the unit goes from busy to idle
    a_mm_done: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> $past(mm_rsp.busy) && !mm_rsp.busy)
        else $error("multiplier done without a running product");
`endif

endmodule

FILE: verif/primality_test_64bit_top_test.sv
// Self-checking testbench for the 64-bit primality tester: directed table plus random requests.
module primality_test_64bit_top_test;

    typedef logic [pmt_pkg::WORD_W-1:0] word_t;

    // One row of the directed table. has_answer marks rows whose answer is typed in.
    typedef struct {
        word_t value;
        bit    has_answer;
        bit    answer;
    } probe_row_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    word_t candidate;
    logic  out_valid;
    logic  out_ready;
    logic  is_prime;

    // Verdicts still owed by the block, oldest first.
    bit     verdict_q[$];
    int     mismatches;
    int     requests_sent;
    int     verdicts_seen;
    int     primes_seen;
    longint cycle_count;

    // Idle percentages for each side; hold_left forces a long receiver hold-off.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    primality_test_64bit_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Primality predictor, written with exact 128-bit products
    // ------------------------------------------------------------------
    function automatic word_t mul_mod_n(input word_t a, input word_t b, input word_t m);
        logic [127:0] prod;
        begin
            prod = {64'd0, a} * {64'd0, b};
            return word_t'(prod % {64'd0, m});
        end
    endfunction

    function automatic word_t pow_mod_n(input word_t base, input word_t e, input word_t m);
        word_t acc;
        word_t sq;
        word_t ex;
        begin
            acc = 64'd1 % m;
            sq  = base % m;
            ex  = e;
            while (ex != 0)
            begin
                if (ex[0])
                    acc = mul_mod_n(acc, sq, m);
                sq = mul_mod_n(sq, sq, m);
                ex = ex >> 1;
            end
            return acc;
        end
    endfunction

    // Strong probable-prime test of odd n against one witness.
    function automatic bit witness_passes(input word_t n, input word_t a,
                                          input int s, input word_t d);
        word_t x;
        begin
            x = pow_mod_n(a, d, n);
            if (x == 1 || x == n - 1)
                return 1'b1;
            for (int j = 1; j < s; j++)
            begin
                x = mul_mod_n(x, x, n);
                if (x == n - 1)
                    return 1'b1;
                if (x == 1)
                    return 1'b0;
            end
            return 1'b0;
        end
    endfunction

    // Witness set picked by the range of n; each set is exact over its range.
    function automatic bit strong_verdict(input word_t n);
        word_t wit[$];
        word_t d;
        word_t a;
        int    s;
        begin
            if (n < 64'd341531)
                wit = '{64'd9345883071009581737};
            else if (n < 64'd885594169)
                wit = '{64'd725270293939359937, 64'd3569819667048198375};
            else if (n < 64'd350269456337)
                wit = '{64'd4230279247111683200, 64'd14694767155120705706,
                        64'd16641139526367750375};
            else if (n < 64'd55245642489451)
                wit = '{64'd2, 64'd141889084524735, 64'd1199124725622454117,
                        64'd11096072698276303650};
            else if (n < 64'd7999252175582851)
                wit = '{64'd2, 64'd4130806001517, 64'd149795463772692060,
                        64'd186635894390467037, 64'd3967304179347715805};
            else if (n < 64'd585226005592931977)
                wit = '{64'd2, 64'd123635709730000, 64'd9233062284813009,
                        64'd43835965440333360, 64'd761179012939631437,
                        64'd1263739024124850375};
            else
                wit = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775,
                        64'd9780504, 64'd1795265022};
            d = n - 1;
            s = 0;
            while (d != 0 && !d[0])
            begin
                d = d >> 1;
                s++;
            end
            foreach (wit[i])
            begin
                a = (wit[i] >= n) ? wit[i] % n : wit[i];
                // a witness that reduces to 0 or 1 tells nothing; skip it
                if (a >= 2 && !witness_passes(n, a, s, d))
                    return 1'b0;
            end
            return 1'b1;
        end
    endfunction

    function automatic bit prime_verdict(input word_t n);
        int trial_primes[12] = '{7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
        begin
            if (n == 2 || n == 3 || n == 5)
                return 1'b1;
            if (n < 2 || n % 2 == 0 || n % 3 == 0 || n % 5 == 0)
                return 1'b0;
            if (n < 49)
                return 1'b1;
            foreach (trial_primes[i])
                if (n % trial_primes[i] == 0)
                    return 1'b0;
            if (n < 2809)
                return 1'b1;
            // Fermat range: base-2 test, minus the known base-2 pseudoprimes
            if (n <= 23001)
                return pow_mod_n(64'd2, n, n) == 2 && n != 7957 && n != 8321 &&
                       n != 13747 && n != 18721 && n != 19951;
            return strong_verdict(n);
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: queue a verdict on each accepted request, check each result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (in_valid && in_ready)
            begin
                verdict_q.push_back(prime_verdict(candidate));
                requests_sent++;
            end
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result is_prime=%0b with no request pending",
                                 is_prime);
                end
                else
                begin
                    if (is_prime !== verdict_q[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d is_prime expected %0b got %0b",
                                     verdicts_seen, verdict_q[0], is_prime);
                    end
                    if (verdict_q[0])
                        primes_seen++;
                    void'(verdict_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a forced hold-off while hold_left runs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one request and hold it until accepted; then maybe idle a while.
    task automatic send_request(input word_t value);
        int gap;
        begin
            in_valid  <= 1'b1;
            candidate <= value;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if ($urandom_range(99) < send_idle_pct)
            begin
                gap = $urandom_range(1, 6);
                in_valid  <= 1'b0;
                candidate <= {$urandom, $urandom};
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    // Random candidates: half cheap sizes, then 32-bit odd values, full-width values and large primes.
    function automatic word_t random_candidate();
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                return word_t'($urandom_range(0, 3000));
            else if (pick < 50)
                return word_t'($urandom_range(2809, 23001));
            else if (pick < 70)
                return {32'd0, $urandom} | 64'd1;
            else if (pick < 95)
                return {$urandom, $urandom};
            else if (pick < 98)
                return 64'd18446744073709551557;
            else
                return 64'd9223372036854775783;
        end
    endfunction

    probe_row_t directed[] = '{
        '{64'd0,                       1'b1, 1'b0},  // zero
        '{64'd1,                       1'b1, 1'b0},  // one
        '{64'd2,                       1'b1, 1'b1},
        '{64'd3,                       1'b1, 1'b1},
        '{64'd4,                       1'b1, 1'b0},
        '{64'd5,                       1'b1, 1'b1},
        '{64'd25,                      1'b1, 1'b0},
        '{64'd47,                      1'b1, 1'b1},  // largest small survivor region
        '{64'd49,                      1'b1, 1'b0},
        '{64'd2801,                    1'b0, 1'b0},
        '{64'd2809,                    1'b1, 1'b0},  // 53 squared, first Fermat value
        '{64'd7957,                    1'b1, 1'b0},  // base-2 pseudoprimes
        '{64'd8321,                    1'b1, 1'b0},
        '{64'd13747,                   1'b1, 1'b0},
        '{64'd18721,                   1'b1, 1'b0},
        '{64'd19951,                   1'b1, 1'b0},
        '{64'd23003,                   1'b0, 1'b0},
        '{64'd341531,                  1'b0, 1'b0},
        '{64'd885594169,               1'b0, 1'b0},
        '{64'd3215031751,              1'b0, 1'b0},
        '{64'd350269456337,            1'b0, 1'b0},
        '{64'd585226005592931977,      1'b0, 1'b0},
        '{64'd18446744073709551557,    1'b0, 1'b0},  // largest 64-bit prime
        '{64'hFFFF_FFFF_FFFF_FFFF,     1'b1, 1'b0},  // all ones, divisible by 3
        '{64'h8000_0000_0000_0000,     1'b1, 1'b0}
    };

    initial
    begin
        mismatches    = 0;
        requests_sent = 0;
        verdicts_seen = 0;
        primes_seen   = 0;
        cycle_count   = 0;
        hold_left     = 0;
        send_idle_pct = 25;
        recv_idle_pct = 58;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        candidate     = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed-in answers must also agree with the predictor.
        foreach (directed[i])
        begin
            if (directed[i].has_answer &&
                directed[i].answer != prime_verdict(directed[i].value))
            begin
                mismatches++;
                $display("ERROR: table row %0d answer disagrees with predictor", i);
            end
            send_request(directed[i].value);
        end

        // Drop valid and pause until every owed verdict has arrived.
        in_valid <= 1'b0;
        @(posedge clk);
        wait (verdict_q.size() == 0);
        @(posedge clk);

        // Hold off the receiver while cheap requests keep coming, so the queue fills.
        hold_left <= 3000;
        for (int i = 0; i < 8; i++)
            send_request(word_t'($urandom_range(0, 2000)));

        for (int i = 0; i < 107; i++)
        begin
            if (i == 35)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 25;
            end
            else if (i == 75)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(random_candidate());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then keep the clock running for any stray result.
        wait (verdict_q.size() == 0);
        repeat (200)
            @(posedge clk);

        $display("Covered %0d requests (%0d verdicts, %0d primes) in %0d cycles,",
                 requests_sent, verdicts_seen, primes_seen, cycle_count);
        $display("from screened values through the Fermat range to full 64-bit strong tests.");
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("primality_test_64bit_top_test passed");
        else
            $display("primality_test_64bit_top_test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #200000000;
        $display("primality_test_64bit_top_test failed");
        $finish;
    end

endmodule
